// ===== hdl/pfc_pkg.sv =====
`default_nettype none

package pfc_pkg;

    localparam int SQ_DIM = 5;
    localparam int CODE_W = 5;
    localparam int ROW_W  = SQ_DIM * CODE_W;
    localparam int IDX_W  = 3;

    localparam logic [7:0] ASCII_UC_A = 8'd65;
    localparam logic [7:0] ASCII_UC_Z = 8'd90;
    localparam logic [7:0] ASCII_LC_A = 8'd97;
    localparam logic [7:0] ASCII_LC_Z = 8'd122;
    localparam logic [7:0] CASE_FOLD  = 8'd32;

    localparam logic [2:0] CFG_MODE = 3'd0;
    localparam logic [2:0] CFG_ROW0 = 3'd1;
    localparam logic [2:0] CFG_ROW1 = 3'd2;
    localparam logic [2:0] CFG_ROW2 = 3'd3;
    localparam logic [2:0] CFG_ROW3 = 3'd4;
    localparam logic [2:0] CFG_ROW4 = 3'd5;

    localparam logic [ROW_W-1:0] ROW0_RST = 25'd4294688;
    localparam logic [ROW_W-1:0] ROW1_RST = 25'd10755269;
    localparam logic [ROW_W-1:0] ROW2_RST = 25'd16201099;
    localparam logic [ROW_W-1:0] ROW3_RST = 25'd21613104;
    localparam logic [ROW_W-1:0] ROW4_RST = 25'd27025109;

    typedef logic [ROW_W-1:0] t_row;
    typedef t_row [SQ_DIM-1:0] t_square;
    typedef logic [IDX_W-1:0] t_idx;

    typedef struct packed {
        logic [7:0] first_char;
        logic [7:0] second_char;
    } t_in_item;

    typedef struct packed {
        logic [6:0] out_first;
        logic [6:0] out_second;
        logic       not_in_square;
    } t_out_item;

    typedef struct packed {
        logic found;
        t_idx row;
        t_idx col;
    } t_loc;

    // one step around the square with wrap; decrypt steps backward
    function automatic t_idx pfc_step(input t_idx idx, input logic dec);
        t_idx res;
        if (dec) begin
            res = (idx == t_idx'(0)) ? t_idx'(SQ_DIM - 1) : idx - t_idx'(1);
        end else begin
            res = (idx == t_idx'(SQ_DIM - 1)) ? t_idx'(0) : idx + t_idx'(1);
        end
        return res;
    endfunction

    function automatic logic [6:0] pfc_char(input t_square sq, input t_idx row,
                                            input t_idx col);
        logic [CODE_W-1:0] code;
        logic [7:0]        sum;
        code = sq[row][CODE_W*col +: CODE_W];
        sum  = ASCII_LC_A + {3'b000, code};
        return sum[6:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/pfc_locate.sv =====
`default_nettype none

module pfc_locate
    import pfc_pkg::*;
(
    input  wire logic [7:0] i_char,
    input  wire t_square    i_square,
    output t_loc            o_loc
);

    logic [7:0]        folded;
    logic              is_letter;
    logic [CODE_W-1:0] code;

    always_comb begin
        folded = i_char;
        if (i_char >= ASCII_UC_A && i_char <= ASCII_UC_Z) begin
            folded = i_char + CASE_FOLD;
        end
        is_letter = (folded >= ASCII_LC_A) && (folded <= ASCII_LC_Z);
        code      = CODE_W'(folded - ASCII_LC_A);
    end

    // last match in row-major order wins
    always_comb begin
        o_loc = '0;
        for (int r = 0; r < SQ_DIM; r++) begin
            for (int c = 0; c < SQ_DIM; c++) begin
                if (is_letter && i_square[r][CODE_W*c +: CODE_W] == code) begin
                    o_loc.found = 1'b1;
                    o_loc.row   = t_idx'(r);
                    o_loc.col   = t_idx'(c);
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/playfair_digraph_cipher.sv =====
// Playfair digraph cipher over a 5x5 key square.
//
// Input: one digraph per transfer on i_item, taken at a rising edge with
// start high and busy low. busy is high only while reset is asserted, so
// a new digraph may be transferred in every cycle.
// Output: one result per digraph on o_result, marked by o_valid for exactly
// one cycle. The result path is registered: one input register, then the
// square lookup and Playfair rules into the result register. Throughput is
// one digraph per cycle; the lookup is a parallel compare of each letter
// against all 25 cells.
// There is no output backpressure: the receiver must take o_result when
// o_valid is high.
// Config: i_cfg_wr_en writes i_cfg_wdata into register i_cfg_index
// (0 mode, 1..5 square rows); other indexes are ignored. Write only when
// no digraph is in flight.
// Reset (synchronous, active low) drops any digraph in flight and restores
// encrypt mode and the default square.
`default_nettype none

module playfair_digraph_cipher
    import pfc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire t_in_item         i_item,
    output logic                  o_valid,
    output t_out_item             o_result,
    input  wire logic             i_cfg_wr_en,
    input  wire t_idx             i_cfg_index,
    input  wire logic [ROW_W-1:0] i_cfg_wdata
);

    logic      r_mode;
    t_square   r_square;
    t_in_item  r_in;
    logic      r_in_vld;
    t_out_item r_out;
    logic      r_out_vld;
    t_out_item n_out;

    t_loc loc_a;
    t_loc loc_b;
    t_idx nr_a, nc_a, nr_b, nc_b;

    assign busy = ~i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b0;
            r_square[0] <= ROW0_RST;
            r_square[1] <= ROW1_RST;
            r_square[2] <= ROW2_RST;
            r_square[3] <= ROW3_RST;
            r_square[4] <= ROW4_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_MODE: r_mode      <= i_cfg_wdata[0];
                CFG_ROW0: r_square[0] <= i_cfg_wdata;
                CFG_ROW1: r_square[1] <= i_cfg_wdata;
                CFG_ROW2: r_square[2] <= i_cfg_wdata;
                CFG_ROW3: r_square[3] <= i_cfg_wdata;
                CFG_ROW4: r_square[4] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= start & ~busy;
        end
        if (start && !busy) begin
            r_in <= i_item;
        end
    end

    pfc_locate u_loc_a (
        .i_char   (r_in.first_char),
        .i_square (r_square),
        .o_loc    (loc_a)
    );

    pfc_locate u_loc_b (
        .i_char   (r_in.second_char),
        .i_square (r_square),
        .o_loc    (loc_b)
    );

    always_comb begin
        nr_a = loc_a.row;
        nc_a = loc_a.col;
        nr_b = loc_b.row;
        nc_b = loc_b.col;
        if (loc_a.col == loc_b.col) begin
            nr_a = pfc_step(loc_a.row, r_mode);
            nr_b = pfc_step(loc_b.row, r_mode);
        end else if (loc_a.row == loc_b.row) begin
            nc_a = pfc_step(loc_a.col, r_mode);
            nc_b = pfc_step(loc_b.col, r_mode);
        end else begin
            nc_a = loc_b.col;
            nc_b = loc_a.col;
        end

        if (loc_a.found && loc_b.found) begin
            n_out.out_first     = pfc_char(r_square, nr_a, nc_a);
            n_out.out_second    = pfc_char(r_square, nr_b, nc_b);
            n_out.not_in_square = 1'b0;
        end else begin
            n_out.out_first     = '0;
            n_out.out_second    = '0;
            n_out.not_in_square = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_in_vld;
        end
        if (r_in_vld) begin
            r_out <= n_out;
        end
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_out;

    a_result_follows_transfer: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, 2) && !$past(busy, 2)
    ) else $error("result without a matching input transfer");

    a_error_zeroes_chars: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.not_in_square) |->
            (o_result.out_first == 7'd0 && o_result.out_second == 7'd0)
    ) else $error("error result carries nonzero characters");

    a_error_flag_matches_lookup: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_result.not_in_square == $past(!(loc_a.found && loc_b.found))
    ) else $error("error flag disagrees with square lookup");

endmodule

`default_nettype wire
